// ===== rtl/core/font_glyph_blitter_assert.svh =====
// ----------------------------------------------------------------------------
// Font glyph blitter assertion macros
// Shared concurrent assertion forms for the glyph blitter RTL.
// ----------------------------------------------------------------------------
`ifndef FONT_GLYPH_BLITTER_ASSERT_SVH
`define FONT_GLYPH_BLITTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FGB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FGB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/fgb_pkg.sv =====
// ----------------------------------------------------------------------------
// fgb_pkg
// Types, constants and register map of the font glyph blitter.
// ----------------------------------------------------------------------------
package fgb_pkg;

   localparam int ATLAS_MAX_W_DEF = 128;
   localparam int ATLAS_ROWS_DEF  = 64;
   localparam int MAX_GLYPH_DEF   = 8;

   localparam int CALC_W  = 21;
   localparam int CELL_W  = 12;
   localparam int GLYPH_W = 4;
   localparam int DIV_W   = 8;
   localparam int CSR_AW  = 5;

   localparam logic [1:0] FUNC_LOAD  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_DRAW  = 2'd2;

   localparam logic [7:0]  INK_FIRST = 8'h20;
   localparam logic [7:0]  INK_LAST  = 8'h7e;
   localparam logic [12:0] PEN_X_MAX = 13'h1fff;
   localparam logic [12:0] PIX_LIMIT = 13'd4096;

   localparam logic [2:0] REG_BUFFER_WIDTH    = 3'd0;
   localparam logic [2:0] REG_BUFFER_HEIGHT   = 3'd1;
   localparam logic [2:0] REG_ATLAS_WIDTH     = 3'd2;
   localparam logic [2:0] REG_SYMBOLS_PER_ROW = 3'd3;
   localparam logic [2:0] REG_GLYPH_HEIGHT    = 3'd4;

   localparam logic [12:0] BUFFER_WIDTH_RST    = 13'd320;
   localparam logic [12:0] BUFFER_HEIGHT_RST   = 13'd200;
   localparam logic [7:0]  ATLAS_WIDTH_RST     = 8'd128;
   localparam logic [7:0]  SYMBOLS_PER_ROW_RST = 8'd16;
   localparam logic [3:0]  GLYPH_HEIGHT_RST    = 4'd8;

   typedef struct packed {
      logic [12:0] buffer_width;
      logic [12:0] buffer_height;
      logic [7:0]  atlas_width;
      logic [7:0]  symbols_per_row;
      logic [3:0]  glyph_height;
   } cfg_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DIV_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
      logic [DIV_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/core/fgb_if.sv =====
// ----------------------------------------------------------------------------
// fgb_req_if / fgb_rsp_if
// Valid/ready channels carrying blitter items and pixel results.
// ----------------------------------------------------------------------------
interface fgb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  char_code;
   logic [11:0] pen_start_x;
   logic [11:0] pen_start_y;
   logic [31:0] text_color;
   logic [12:0] atlas_addr;
   logic        atlas_ink;

   modport source (output valid, func, char_code, pen_start_x, pen_start_y, text_color,
                   atlas_addr, atlas_ink, input ready);
   modport sink (input valid, func, char_code, pen_start_x, pen_start_y, text_color,
                 atlas_addr, atlas_ink, output ready);
endinterface

interface fgb_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] pix_x;
   logic [11:0] pix_y;
   logic [31:0] pix_color;
   logic        oob_error;
   logic        last;

   modport source (output valid, pix_x, pix_y, pix_color, oob_error, last, input ready);
   modport sink (input valid, pix_x, pix_y, pix_color, oob_error, last, output ready);
endinterface

// ===== rtl/core/fgb_ram.sv =====
// ----------------------------------------------------------------------------
// fgb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fgb_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/fgb_div.sv =====
// ----------------------------------------------------------------------------
// fgb_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fgb_div (
   input  logic                clock,
   input  logic                reset,
   input  fgb_pkg::div_req_type req,
   output fgb_pkg::div_rsp_type rsp
);

   localparam int CntW = $clog2(fgb_pkg::DIV_W);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CntW-1:0]          cnt_ff, cnt_in;
   logic [fgb_pkg::DIV_W-1:0] dvd_ff, dvd_in;
   logic [fgb_pkg::DIV_W-1:0] dvs_ff, dvs_in;
   logic [fgb_pkg::DIV_W-1:0] rem_ff, rem_in;
   logic [fgb_pkg::DIV_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[fgb_pkg::DIV_W-1]};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = req.dividend;
         dvs_in  = req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = fgb_pkg::DIV_W'(trial - {1'b0, dvs_ff});
            dvd_in = {dvd_ff[fgb_pkg::DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[fgb_pkg::DIV_W-1:0];
            dvd_in = {dvd_ff[fgb_pkg::DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntW'(fgb_pkg::DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = dvd_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ===== rtl/core/fgb_csr.sv =====
// ----------------------------------------------------------------------------
// fgb_csr
// APB-style configuration registers of the glyph blitter.
// ----------------------------------------------------------------------------
module fgb_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [fgb_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready,
   output fgb_pkg::cfg_type            cfg
);

   fgb_pkg::cfg_type cfg_ff, cfg_in;
   logic [2:0]       index;
   logic             wr;

   assign index  = paddr[fgb_pkg::CSR_AW-1:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (index)
            fgb_pkg::REG_BUFFER_WIDTH:    cfg_in.buffer_width    = pwdata[12:0];
            fgb_pkg::REG_BUFFER_HEIGHT:   cfg_in.buffer_height   = pwdata[12:0];
            fgb_pkg::REG_ATLAS_WIDTH:     cfg_in.atlas_width     = pwdata[7:0];
            fgb_pkg::REG_SYMBOLS_PER_ROW: cfg_in.symbols_per_row = pwdata[7:0];
            fgb_pkg::REG_GLYPH_HEIGHT:    cfg_in.glyph_height    = pwdata[3:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         fgb_pkg::REG_BUFFER_WIDTH:    prdata = {19'd0, cfg_ff.buffer_width};
         fgb_pkg::REG_BUFFER_HEIGHT:   prdata = {19'd0, cfg_ff.buffer_height};
         fgb_pkg::REG_ATLAS_WIDTH:     prdata = {24'd0, cfg_ff.atlas_width};
         fgb_pkg::REG_SYMBOLS_PER_ROW: prdata = {24'd0, cfg_ff.symbols_per_row};
         fgb_pkg::REG_GLYPH_HEIGHT:    prdata = {28'd0, cfg_ff.glyph_height};
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.buffer_width    <= fgb_pkg::BUFFER_WIDTH_RST;
         cfg_ff.buffer_height   <= fgb_pkg::BUFFER_HEIGHT_RST;
         cfg_ff.atlas_width     <= fgb_pkg::ATLAS_WIDTH_RST;
         cfg_ff.symbols_per_row <= fgb_pkg::SYMBOLS_PER_ROW_RST;
         cfg_ff.glyph_height    <= fgb_pkg::GLYPH_HEIGHT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/font_glyph_blitter.sv =====
// ----------------------------------------------------------------------------
// font_glyph_blitter
// Bitmap font character generator writing clipped frame-buffer pixels.
//
//   Channel   Direction  Handshake           Transfer
//   req_chan  in         valid/ready         load, start or draw item
//   rsp_chan  out        valid/ready         one pixel write or error
//   csr       in         psel/penable/pready one register write or read
//
// Load and start items leave the block idle, ready for the next item.
// A draw item first runs its setup (two passes of the shared divider, two
// multiply steps), then reads each atlas pixel through the mask RAM port and
// checks it, and ends each row at the glyph width or by clipping.
// After reset the mask RAM is cleared one entry per cycle, all ATLAS_MAX_W times
// ATLAS_ROWS entries (8192 by default), during which no item is taken.
// A stalled result channel holds the scan when a second ink pixel is found.
// ----------------------------------------------------------------------------
`include "font_glyph_blitter_assert.svh"

module font_glyph_blitter #(
   parameter int ATLAS_MAX_W = fgb_pkg::ATLAS_MAX_W_DEF,
   parameter int ATLAS_ROWS  = fgb_pkg::ATLAS_ROWS_DEF,
   parameter int MAX_GLYPH   = fgb_pkg::MAX_GLYPH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   fgb_req_if.sink                    req_chan,
   fgb_rsp_if.source                  rsp_chan,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [fgb_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int AtlasDepth = ATLAS_MAX_W * ATLAS_ROWS;
   localparam int RamAw      = $clog2(AtlasDepth);
   localparam int CW         = fgb_pkg::CALC_W;
   localparam int GW         = fgb_pkg::GLYPH_W;
   localparam logic [GW-1:0] MaxGlyph = GW'(MAX_GLYPH);

   typedef enum logic [10:0] {
      ST_IDLE      = 11'b000_0000_0001,
      ST_CLEAR     = 11'b000_0000_0010,
      ST_DIVW_GO   = 11'b000_0000_0100,
      ST_DIVW_WAIT = 11'b000_0000_1000,
      ST_DIVI_GO   = 11'b000_0001_0000,
      ST_DIVI_WAIT = 11'b000_0010_0000,
      ST_MUL_CELL  = 11'b000_0100_0000,
      ST_MUL_BASE  = 11'b000_1000_0000,
      ST_SCAN_RD   = 11'b001_0000_0000,
      ST_SCAN_CHK  = 11'b010_0000_0000,
      ST_FLUSH     = 11'b100_0000_0000
   } state_type;

   fgb_pkg::cfg_type     cfg;
   fgb_pkg::div_req_type div_req;
   fgb_pkg::div_rsp_type div_rsp;

   state_type                   state_ff, state_in;
   logic [RamAw-1:0]            clr_cnt_ff, clr_cnt_in;
   logic                        active_ff, active_in;
   logic [12:0]                 pen_x_ff, pen_x_in;
   logic [11:0]                 pen_y_ff, pen_y_in;
   logic [31:0]                 pen_color_ff, pen_color_in;
   logic                        adv_ff, adv_in;
   logic [7:0]                  idx_ff, idx_in;
   logic [GW-1:0]               gw_ff, gw_in;
   logic [7:0]                  quo_ff, quo_in;
   logic [7:0]                  rem_ff, rem_in;
   logic [fgb_pkg::CELL_W-1:0]  gx_ff, gx_in;
   logic [fgb_pkg::CELL_W-1:0]  gy_ff, gy_in;
   logic [CW-1:0]               row_addr_ff, row_addr_in;
   logic [GW-1:0]               x_ff, x_in;
   logic [GW-1:0]               y_ff, y_in;
   logic                        addr_ok_ff, addr_ok_in;
   logic                        held_vld_ff, held_vld_in;
   logic [11:0]                 held_x_ff, held_x_in;
   logic [11:0]                 held_y_ff, held_y_in;
   logic                        held_err_ff, held_err_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   logic [11:0]                 rsp_x_ff, rsp_x_in;
   logic [11:0]                 rsp_y_ff, rsp_y_in;
   logic [31:0]                 rsp_color_ff, rsp_color_in;
   logic                        rsp_err_ff, rsp_err_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        accept;
   logic                        out_free;
   logic [7:0]                  spr_eff;
   logic [GW-1:0]               gh_eff;
   logic [12:0]                 xlim;
   logic [12:0]                 ylim;
   logic [13:0]                 px_sum;
   logic [12:0]                 py_sum;
   logic [13:0]                 adv_sum;
   logic [CW-1:0]               rd_calc;
   logic [CW-1:0]               load_calc;
   logic                        ink;
   logic                        printable;
   logic                        oob;
   logic                        load_we;
   logic                        ram_we;
   logic [RamAw-1:0]            ram_waddr;
   logic                        ram_wdata;
   logic                        ram_re;
   logic                        ram_rdata;

   fgb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fgb_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   fgb_ram #(
      .WIDTH (1),
      .DEPTH (AtlasDepth)
   ) u_atlas (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (rd_calc[RamAw-1:0]),
      .rdata (ram_rdata)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_vld_ff || rsp_chan.ready;

   assign spr_eff = (cfg.symbols_per_row == 8'd0) ? 8'd1 : cfg.symbols_per_row;
   assign gh_eff  = (cfg.glyph_height > MaxGlyph) ? MaxGlyph : cfg.glyph_height;
   assign xlim    = (cfg.buffer_width > fgb_pkg::PIX_LIMIT) ? fgb_pkg::PIX_LIMIT
                                                            : cfg.buffer_width;
   assign ylim    = (cfg.buffer_height > fgb_pkg::PIX_LIMIT) ? fgb_pkg::PIX_LIMIT
                                                             : cfg.buffer_height;
   assign px_sum  = {1'b0, pen_x_ff} + 14'(x_ff);
   assign py_sum  = {1'b0, pen_y_ff} + 13'(y_ff);
   assign adv_sum = {1'b0, pen_x_ff} + 14'(gw_ff);
   assign rd_calc = row_addr_ff + CW'(x_ff);
   assign ink     = ram_rdata && addr_ok_ff;

   assign load_calc = CW'(req_chan.atlas_addr);
   assign printable = (req_chan.char_code >= fgb_pkg::INK_FIRST) &&
                      (req_chan.char_code <= fgb_pkg::INK_LAST);
   assign oob       = (pen_x_ff > cfg.buffer_width) ||
                      ({1'b0, pen_y_ff} > cfg.buffer_height);
   assign load_we   = accept && (req_chan.func == fgb_pkg::FUNC_LOAD) &&
                      (load_calc < CW'(AtlasDepth));

   assign ram_we    = (state_ff == ST_CLEAR) || load_we;
   assign ram_waddr = (state_ff == ST_CLEAR) ? clr_cnt_ff : load_calc[RamAw-1:0];
   assign ram_wdata = (state_ff == ST_CLEAR) ? 1'b0 : req_chan.atlas_ink;

   assign div_req.start    = (state_ff == ST_DIVW_GO) || (state_ff == ST_DIVI_GO);
   assign div_req.dividend = (state_ff == ST_DIVW_GO) ? cfg.atlas_width : idx_ff;
   assign div_req.divisor  = spr_eff;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      active_in    = active_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      pen_color_in = pen_color_ff;
      adv_in       = adv_ff;
      idx_in       = idx_ff;
      gw_in        = gw_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      row_addr_in  = row_addr_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      addr_ok_in   = addr_ok_ff;
      held_vld_in  = held_vld_ff;
      held_x_in    = held_x_ff;
      held_y_in    = held_y_ff;
      held_err_in  = held_err_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_color_in = rsp_color_ff;
      rsp_err_in   = rsp_err_ff;
      rsp_last_in  = rsp_last_ff;
      ram_re       = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == RamAw'(AtlasDepth - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_chan.func)
                  fgb_pkg::FUNC_START: begin
                     pen_x_in     = {1'b0, req_chan.pen_start_x};
                     pen_y_in     = req_chan.pen_start_y;
                     pen_color_in = req_chan.text_color;
                     active_in    = 1'b1;
                  end
                  fgb_pkg::FUNC_DRAW: begin
                     if (active_ff) begin
                        if (!printable) begin
                           active_in = 1'b0;
                        end else if (oob) begin
                           active_in   = 1'b0;
                           adv_in      = 1'b0;
                           held_vld_in = 1'b1;
                           held_x_in   = '0;
                           held_y_in   = '0;
                           held_err_in = 1'b1;
                           state_in    = ST_FLUSH;
                        end else begin
                           adv_in   = 1'b1;
                           idx_in   = req_chan.char_code - fgb_pkg::INK_FIRST;
                           state_in = ST_DIVW_GO;
                        end
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIVW_GO: begin
            state_in = ST_DIVW_WAIT;
         end
         ST_DIVW_WAIT: begin
            if (div_rsp.done) begin
               gw_in    = (div_rsp.quotient > 8'(MAX_GLYPH)) ? MaxGlyph
                                                             : div_rsp.quotient[GW-1:0];
               state_in = ST_DIVI_GO;
            end
         end
         ST_DIVI_GO: begin
            state_in = ST_DIVI_WAIT;
         end
         ST_DIVI_WAIT: begin
            if (div_rsp.done) begin
               quo_in   = div_rsp.quotient;
               rem_in   = div_rsp.remainder;
               state_in = ST_MUL_CELL;
            end
         end
         ST_MUL_CELL: begin
            gx_in    = fgb_pkg::CELL_W'(rem_ff) * fgb_pkg::CELL_W'(gw_ff);
            gy_in    = fgb_pkg::CELL_W'(quo_ff) * fgb_pkg::CELL_W'(gh_eff);
            state_in = ST_MUL_BASE;
         end
         ST_MUL_BASE: begin
            row_addr_in = CW'(gy_ff) * CW'(cfg.atlas_width) + CW'(gx_ff);
            x_in        = '0;
            y_in        = '0;
            state_in    = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if ((y_ff >= gh_eff) || (py_sum >= ylim)) begin
               state_in = ST_FLUSH;
            end else if ((x_ff >= gw_ff) || (px_sum >= {1'b0, xlim})) begin
               x_in        = '0;
               y_in        = y_ff + 1'b1;
               row_addr_in = row_addr_ff + CW'(cfg.atlas_width);
            end else begin
               ram_re     = 1'b1;
               addr_ok_in = rd_calc < CW'(AtlasDepth);
               state_in   = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (!ink || !held_vld_ff || out_free) begin
               if (ink) begin
                  if (held_vld_ff) begin
                     rsp_vld_in   = 1'b1;
                     rsp_x_in     = held_x_ff;
                     rsp_y_in     = held_y_ff;
                     rsp_color_in = pen_color_ff;
                     rsp_err_in   = 1'b0;
                     rsp_last_in  = 1'b0;
                  end
                  held_vld_in = 1'b1;
                  held_x_in   = px_sum[11:0];
                  held_y_in   = py_sum[11:0];
                  held_err_in = 1'b0;
               end
               x_in     = x_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end
         ST_FLUSH: begin
            if (!held_vld_ff || out_free) begin
               if (held_vld_ff) begin
                  rsp_vld_in   = 1'b1;
                  rsp_x_in     = held_x_ff;
                  rsp_y_in     = held_y_ff;
                  rsp_color_in = held_err_ff ? 32'd0 : pen_color_ff;
                  rsp_err_in   = held_err_ff;
                  rsp_last_in  = 1'b1;
               end
               held_vld_in = 1'b0;
               if (adv_ff) begin
                  pen_x_in = adv_sum[13] ? fgb_pkg::PEN_X_MAX : adv_sum[12:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         active_ff    <= 1'b0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         pen_color_ff <= '0;
         held_vld_ff  <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         active_ff    <= active_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
         pen_color_ff <= pen_color_in;
         held_vld_ff  <= held_vld_in;
         rsp_vld_ff   <= rsp_vld_in;
      end
      adv_ff       <= adv_in;
      idx_ff       <= idx_in;
      gw_ff        <= gw_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      row_addr_ff  <= row_addr_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      addr_ok_ff   <= addr_ok_in;
      held_x_ff    <= held_x_in;
      held_y_ff    <= held_y_in;
      held_err_ff  <= held_err_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_color_ff <= rsp_color_in;
      rsp_err_ff   <= rsp_err_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_vld_ff;
   assign rsp_chan.pix_x     = rsp_x_ff;
   assign rsp_chan.pix_y     = rsp_y_ff;
   assign rsp_chan.pix_color = rsp_color_ff;
   assign rsp_chan.oob_error = rsp_err_ff;
   assign rsp_chan.last      = rsp_last_ff;

   `FGB_ASSERT_IMP(a_err_is_last, clock, reset, rsp_vld_ff && rsp_err_ff, rsp_last_ff, "error result without last")
   `FGB_ASSERT_IMP(a_div_done_waited, clock, reset, div_rsp.done, state_ff == ST_DIVW_WAIT || state_ff == ST_DIVI_WAIT, "divider finished outside a wait state")
   `FGB_ASSERT_IMP(a_ram_write_idle, clock, reset, ram_we, state_ff == ST_IDLE || state_ff == ST_CLEAR, "mask write during a draw")
   `FGB_ASSERT_NXT(a_held_kept, clock, reset, state_ff == ST_SCAN_CHK && held_vld_ff, held_vld_ff, "held result dropped during scan")

endmodule
